FILE: rtl/qmn_pkg.sv
`default_nettype none
package qmn_pkg;

  // operation codes
  localparam logic [2:0] OP_MUL        = 3'd0;
  localparam logic [2:0] OP_MUL_CONJ_B = 3'd1;
  localparam logic [2:0] OP_MUL_CONJ_A = 3'd2;
  localparam logic [2:0] OP_NORM_A     = 3'd3;
  localparam logic [2:0] OP_CONJ_A     = 3'd4;

  localparam int PW = 32;          // port part width, Q2.30
  localparam int CW = 36;          // signed product part
  localparam int MW = 35;          // magnitude of a product part
  localparam int QW = 70;          // square of one magnitude
  localparam int SW = 72;          // sum of squares
  localparam int NW = 36;          // integer square root
  localparam int RW = 40;          // square root remainder
  localparam int SQRT_PER    = 2;  // root bits resolved per stage
  localparam int SQRT_STAGES = NW / SQRT_PER;

  localparam logic [PW-1:0] UNIT_ONE = PW'(1) << 30;

  typedef struct packed {
    logic [2:0]           op;
    logic [3:0]           neg;
    logic [3:0][MW-1:0]   mag;
  } side_t;

endpackage
`default_nettype wire

FILE: rtl/qmn_sqrt.sv
`default_nettype none
module qmn_sqrt (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire                    in_valid,
  input  wire qmn_pkg::side_t    in_side,
  input  wire [qmn_pkg::SW-1:0]  in_s,
  output logic                   out_valid,
  output qmn_pkg::side_t         out_side,
  output logic [qmn_pkg::NW-1:0] out_root
);

  typedef struct packed {
    logic [qmn_pkg::SW-1:0] s;
    logic [qmn_pkg::RW-1:0] rem;
    logic [qmn_pkg::NW-1:0] root;
  } sq_t;

  // digit recurrence, two bits of the radicand per root bit
  function automatic sq_t sq_steps(sq_t x);
    sq_t                    y;
    logic [qmn_pkg::RW-1:0] r2;
    logic [qmn_pkg::RW-1:0] trial;
    y = x;
    for (int i = 0; i < qmn_pkg::SQRT_PER; i++) begin
      r2    = {y.rem[qmn_pkg::RW-3:0], y.s[qmn_pkg::SW-1 -: 2]};
      y.s   = {y.s[qmn_pkg::SW-3:0], 2'b00};
      trial = qmn_pkg::RW'({y.root, 2'b01});
      if (r2 >= trial) begin
        y.rem  = r2 - trial;
        y.root = {y.root[qmn_pkg::NW-2:0], 1'b1};
      end else begin
        y.rem  = r2;
        y.root = {y.root[qmn_pkg::NW-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  localparam int N = qmn_pkg::SQRT_STAGES;

  logic [N-1:0]   v_r;
  sq_t            st_r [N];
  qmn_pkg::side_t sd_r [N];
  sq_t            entry_nxt;

  assign entry_nxt = '{s: in_s, rem: '0, root: '0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= sq_steps(entry_nxt);
      sd_r[0] <= in_side;
      for (int k = 1; k < N; k++) begin
        st_r[k] <= sq_steps(st_r[k-1]);
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_side  = sd_r[N-1];
  assign out_root  = st_r[N-1].root;

endmodule
`default_nettype wire

FILE: rtl/quaternion_multiply_normalize_top.sv
`default_nettype none
// Quaternion product and normalization pipeline.
// Input channel in_*: in_tuser carries the operation code (a*b, a*conj(b),
// conj(a)*b, normalize a, conjugate a); in_tdata carries quaternions a and b
// as eight signed Q2.30 parts. Output channel out_*: out_tdata carries the four
// result parts, then the pre-normalization magnitude in unsigned Q4.28
// (saturating); out_tuser flags a zero norm whose result was forced to zero.
// A transfer happens on a clock edge with tvalid and tready both high.
// One item enters per cycle unless the output stalls, and each result passes
// through 5 stages for products, sums, squares and their total,
// 18 square-root stages at two root bits each, 16 stages of restoring
// division (the leading quotient bit, then two bits per stage) over four
// lanes, and the output register.
// When out_tready is low with a result pending, the whole pipeline holds
// and in_tready drops; nothing is lost or repeated.
// A synchronous low rst_n empties the pipeline; no result is pending after.
module quaternion_multiply_normalize_top (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // a_scalar, a_x, a_y, a_z, b_scalar, b_x, b_y, b_z
  input  wire [255:0]  in_tdata,
  // operation
  input  wire [2:0]    in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // r_scalar, r_x, r_y, r_z, magnitude
  output logic [159:0] out_tdata,
  // degenerate
  output logic [0:0]   out_tuser
);

  localparam int PW = qmn_pkg::PW;
  localparam int CW = qmn_pkg::CW;
  localparam int MW = qmn_pkg::MW;
  localparam int NW = qmn_pkg::NW;
  localparam int DW = NW + 1;
  localparam int FW = 31;          // quotient bits
  localparam int DIV_PER    = 2;
  localparam int DIV_STAGES = (FW - 1) / DIV_PER;

  typedef struct packed {
    qmn_pkg::side_t       side;
    logic [NW-1:0]        n;
    logic [3:0][DW-1:0]   rem;
    logic [3:0][FW-1:0]   q;
    logic [PW-1:0]        mag;
    logic                 degen;
  } div_stage_t;

  function automatic div_stage_t div_steps(div_stage_t x);
    div_stage_t    y;
    logic [DW-1:0] r2;
    y = x;
    for (int l = 0; l < 4; l++) begin
      for (int i = 0; i < DIV_PER; i++) begin
        r2 = {y.rem[l][DW-2:0], 1'b0};
        if (r2 >= DW'(y.n)) begin
          y.rem[l] = r2 - DW'(y.n);
          y.q[l]   = {y.q[l][FW-2:0], 1'b1};
        end else begin
          y.rem[l] = r2;
          y.q[l]   = {y.q[l][FW-2:0], 1'b0};
        end
      end
    end
    return y;
  endfunction

  logic en;
  logic out_v_r;
  assign en         = !out_v_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_v_r;

  // stage 1: conjugation and sixteen partial products, floored
  logic signed [32:0]   qa  [4];
  logic signed [32:0]   qb  [4];
  logic signed [65:0]   pf  [4][4];
  logic signed [CW-1:0] p1_r [4][4];
  logic signed [PW-1:0] a1_r [4];
  logic [2:0]           op1_r;
  logic                 v1_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qa[i] = 33'($signed(in_tdata[32*i +: 32]));
      qb[i] = 33'($signed(in_tdata[128 + 32*i +: 32]));
      if (i != 0 && in_tuser == qmn_pkg::OP_MUL_CONJ_A) qa[i] = -qa[i];
      if (i != 0 && in_tuser == qmn_pkg::OP_MUL_CONJ_B) qb[i] = -qb[i];
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pf[i][j] = 66'(qa[i]) * 66'(qb[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p1_r[i][j] <= pf[i][j][65:30];
        end
        a1_r[i] <= $signed(in_tdata[32*i +: 32]);
      end
      op1_r <= in_tuser;
    end
  end

  // stage 2: Hamilton sums, or operand a passed through for the other operations
  logic signed [CW-1:0] c2_nxt [4];
  logic signed [CW-1:0] c2_r   [4];
  logic [2:0]           op2_r;
  logic                 v2_r;

  always_comb begin
    if (op1_r == qmn_pkg::OP_MUL || op1_r == qmn_pkg::OP_MUL_CONJ_B ||
        op1_r == qmn_pkg::OP_MUL_CONJ_A) begin
      c2_nxt[0] = p1_r[0][0] - p1_r[1][1] - p1_r[2][2] - p1_r[3][3];
      c2_nxt[1] = p1_r[0][1] + p1_r[1][0] + p1_r[2][3] - p1_r[3][2];
      c2_nxt[2] = p1_r[0][2] - p1_r[1][3] + p1_r[2][0] + p1_r[3][1];
      c2_nxt[3] = p1_r[0][3] + p1_r[1][2] - p1_r[2][1] + p1_r[3][0];
    end else begin
      for (int i = 0; i < 4; i++) c2_nxt[i] = CW'(a1_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r  <= c2_nxt;
      op2_r <= op1_r;
    end
  end

  // stage 3: sign flip on a negative scalar product, then sign and magnitude
  qmn_pkg::side_t       sd3_nxt;
  qmn_pkg::side_t       sd3_r;
  logic                 v3_r;
  logic                 flip;
  logic signed [CW-1:0] cf [4];
  logic signed [CW-1:0] ca [4];

  always_comb begin
    flip = c2_r[0][CW-1] && (op2_r == qmn_pkg::OP_MUL ||
           op2_r == qmn_pkg::OP_MUL_CONJ_B || op2_r == qmn_pkg::OP_MUL_CONJ_A);
    sd3_nxt.op = op2_r;
    for (int i = 0; i < 4; i++) begin
      cf[i] = flip ? -c2_r[i] : c2_r[i];
      ca[i] = cf[i][CW-1] ? -cf[i] : cf[i];
      sd3_nxt.neg[i] = cf[i][CW-1];
      sd3_nxt.mag[i] = ca[i][MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) sd3_r <= sd3_nxt;
  end

  // stage 4: squares
  logic [qmn_pkg::QW-1:0] sq4_r [4];
  qmn_pkg::side_t         sd4_r;
  logic                   v4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq4_r[i] <= qmn_pkg::QW'(sd3_r.mag[i]) * qmn_pkg::QW'(sd3_r.mag[i]);
      end
      sd4_r <= sd3_r;
    end
  end

  // stage 5: sum of squares
  logic [qmn_pkg::SW-1:0] s5_r;
  qmn_pkg::side_t         sd5_r;
  logic                   v5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r  <= qmn_pkg::SW'(sq4_r[0]) + qmn_pkg::SW'(sq4_r[1]) +
               qmn_pkg::SW'(sq4_r[2]) + qmn_pkg::SW'(sq4_r[3]);
      sd5_r <= sd4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  logic           sq_valid;
  qmn_pkg::side_t sq_side;
  logic [NW-1:0]  sq_root;

  qmn_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_side   (sd5_r),
    .in_s      (s5_r),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_root  (sq_root)
  );

  // division setup: leading quotient bit needs no shift since |c| <= n
  div_stage_t d0_nxt;
  always_comb begin
    d0_nxt.side  = sq_side;
    d0_nxt.n     = sq_root;
    d0_nxt.degen = (sq_root == '0);
    d0_nxt.mag   = (|sq_root[NW-1:34]) ? '1 : sq_root[33:2];
    for (int l = 0; l < 4; l++) begin
      if (DW'(sq_side.mag[l]) >= DW'(sq_root)) begin
        d0_nxt.rem[l] = DW'(sq_side.mag[l]) - DW'(sq_root);
        d0_nxt.q[l]   = FW'(1);
      end else begin
        d0_nxt.rem[l] = DW'(sq_side.mag[l]);
        d0_nxt.q[l]   = '0;
      end
    end
  end

  div_stage_t          dv_r [DIV_STAGES+1];
  logic [DIV_STAGES:0] dv_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r <= '0;
    end else if (en) begin
      dv_v_r <= {dv_v_r[DIV_STAGES-1:0], sq_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= d0_nxt;
      for (int k = 1; k <= DIV_STAGES; k++) dv_r[k] <= div_steps(dv_r[k-1]);
    end
  end

  // result assembly
  div_stage_t    dl;
  logic [PW-1:0] part [4];
  logic [PW-1:0] mq   [4];
  logic [PW-1:0] mag_nxt;
  logic          degen_nxt;

  assign dl = dv_r[DIV_STAGES];

  always_comb begin
    mag_nxt   = '0;
    degen_nxt = 1'b0;
    for (int l = 0; l < 4; l++) begin
      part[l] = '0;
      mq[l]   = dl.side.mag[l][PW-1:0];
    end
    case (dl.side.op)
      qmn_pkg::OP_MUL, qmn_pkg::OP_MUL_CONJ_B, qmn_pkg::OP_MUL_CONJ_A,
      qmn_pkg::OP_NORM_A: begin
        mag_nxt   = dl.mag;
        degen_nxt = dl.degen;
        for (int l = 0; l < 4; l++) begin
          if (!dl.degen) part[l] = dl.side.neg[l] ? -PW'(dl.q[l]) : PW'(dl.q[l]);
        end
      end
      qmn_pkg::OP_CONJ_A: begin
        mag_nxt = dl.mag;
        part[0] = dl.side.neg[0] ? -mq[0] : mq[0];
        for (int l = 1; l < 4; l++) begin
          // negating the most negative part saturates
          if (!dl.side.neg[l]) begin
            part[l] = -mq[l];
          end else if (dl.side.mag[l] == MW'(qmn_pkg::UNIT_ONE) << 1) begin
            part[l] = {1'b0, {(PW-1){1'b1}}};
          end else begin
            part[l] = mq[l];
          end
        end
      end
      default: begin
        mag_nxt = '0;
      end
    endcase
  end

  logic [159:0] out_data_r;
  logic         out_degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r  <= {mag_nxt, part[3], part[2], part[1], part[0]};
      out_degen_r <= degen_nxt;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_degen_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("degenerate result with nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline is stalled");

endmodule
`default_nettype wire
